FILE: design/stlb_pkg.sv
// Package for the sorted table lower-bound block: sizes, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package stlb_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int RSP_TDATA_W = ((CNT_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP_MID,
      ST_CMP_LO,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic append;
      logic query;
      logic rd_en;
      logic cmp_mid;
      logic cmp_lo;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic span_multi;
      logic rsp_free;
   } sts_type;

endpackage

FILE: design/sorted_table_lower_bound.sv
// Sorted table lower-bound block. Requests are taken only in the idle state; clear and append
// complete on acceptance. A query runs about log2(element count) midpoint probes plus a final
// probe, each a registered table read followed by a key compare (an empty table skips them);
// the next request is taken once the result is loaded, and a stalled result holds it.
// Synchronous active-high reset clears the element count and the result valid flag;
// table contents are undefined until written. Top level; uses stlb_pkg, stlb_ctrl, stlb_datapath.
module sorted_table_lower_bound (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,   // [31:0] operand_value
   input  logic [1:0]                          req_tuser,   // [1:0] operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stlb_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [10:0] position, rest zero
   output logic                                rsp_tuser    // [0] found
);

   stlb_pkg::cmd_type          cmd;
   stlb_pkg::sts_type          sts;
   logic [stlb_pkg::CNT_W-1:0] position;

   stlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .operation  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stlb_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .operand_value (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .position      (position),
      .found         (rsp_tuser)
   );

   assign rsp_tdata = stlb_pkg::RSP_TDATA_W'(position);

endmodule

FILE: design/stlb_ctrl.sv
// Controller state machine of the sorted table lower-bound block.
// Depends on stlb_pkg for states, operation codes and command/status structs.
module stlb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [1:0]        operation,
   output logic              req_tready,
   input  stlb_pkg::sts_type sts,
   output stlb_pkg::cmd_type cmd
);

   stlb_pkg::state_type state_ff, state_in;
   logic                req_fire;

   assign req_fire = req_tvalid && (state_ff == stlb_pkg::ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stlb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stlb_pkg::ST_IDLE: begin
            if (req_fire && operation == stlb_pkg::OP_QUERY) begin
               state_in = sts.count_zero ? stlb_pkg::ST_FINISH : stlb_pkg::ST_READ;
            end
         end
         stlb_pkg::ST_READ: begin
            state_in = sts.span_multi ? stlb_pkg::ST_CMP_MID : stlb_pkg::ST_CMP_LO;
         end
         stlb_pkg::ST_CMP_MID: state_in = stlb_pkg::ST_READ;
         stlb_pkg::ST_CMP_LO:  state_in = stlb_pkg::ST_FINISH;
         stlb_pkg::ST_FINISH: begin
            if (sts.rsp_free) begin
               state_in = stlb_pkg::ST_IDLE;
            end
         end
         default: state_in = stlb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         stlb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (operation)
                  stlb_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
                  stlb_pkg::OP_APPEND: cmd.append = 1'b1;
                  stlb_pkg::OP_QUERY:  cmd.query  = 1'b1;
                  default: ;
               endcase
            end
         end
         stlb_pkg::ST_READ:    cmd.rd_en    = 1'b1;
         stlb_pkg::ST_CMP_MID: cmd.cmp_mid  = 1'b1;
         stlb_pkg::ST_CMP_LO:  cmd.cmp_lo   = 1'b1;
         stlb_pkg::ST_FINISH:  cmd.load_rsp = sts.rsp_free;
         default: ;
      endcase
   end

endmodule

FILE: design/stlb_datapath.sv
// Datapath of the sorted table lower-bound block: table memory, element count,
// search bounds, key compare and the result register.
// Depends on stlb_pkg.
module stlb_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  stlb_pkg::cmd_type                  cmd,
   output stlb_pkg::sts_type                  sts,
   input  logic signed [stlb_pkg::DATA_W-1:0] operand_value,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [stlb_pkg::CNT_W-1:0]         position,
   output logic                               found
);

   logic signed [stlb_pkg::DATA_W-1:0] store_mem [stlb_pkg::TABLE_DEPTH];
   logic signed [stlb_pkg::DATA_W-1:0] rd_data_ff;
   logic signed [stlb_pkg::DATA_W-1:0] key_ff;
   logic [stlb_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [stlb_pkg::CNT_W-1:0]         lo_ff, lo_in, hi_ff, hi_in, pos_ff, pos_in;
   logic [stlb_pkg::CNT_W-1:0]         span, mid;
   logic [stlb_pkg::ADDR_W-1:0]        rd_addr;
   logic                               not_full, ge;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [stlb_pkg::CNT_W-1:0]         rsp_pos_ff;
   logic                               rsp_found_ff;

   // probe address: middle of [lo,hi) while more than one element, else lo
   assign span     = hi_ff - lo_ff;
   assign mid      = lo_ff + (span >> 1);
   assign rd_addr  = (span > stlb_pkg::CNT_W'(1)) ? mid[stlb_pkg::ADDR_W-1:0]
                                                  : lo_ff[stlb_pkg::ADDR_W-1:0];
   assign not_full = count_ff < stlb_pkg::CNT_W'(stlb_pkg::TABLE_DEPTH);
   assign ge       = rd_data_ff >= key_ff;

   // table memory: write on append, registered read during a probe
   always_ff @(posedge clock) begin
      if (cmd.append && not_full) begin
         store_mem[count_ff[stlb_pkg::ADDR_W-1:0]] <= operand_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // element count
   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.append && not_full) begin
         count_in = count_ff + stlb_pkg::CNT_W'(1);
      end
   end

   // search bounds and answer
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      pos_in = pos_ff;
      if (cmd.query) begin
         lo_in  = '0;
         hi_in  = count_ff;
         pos_in = '0;
      end else if (cmd.cmp_mid) begin
         if (ge) begin
            hi_in = mid;
         end else begin
            lo_in = mid;
         end
      end else if (cmd.cmp_lo) begin
         pos_in = ge ? lo_ff : hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query) begin
         key_ff <= operand_value;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      pos_ff <= pos_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_pos_ff   <= pos_ff;
         rsp_found_ff <= pos_ff < count_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.count_zero = count_ff == '0;
   assign sts.span_multi = span > stlb_pkg::CNT_W'(1);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign position   = rsp_pos_ff;
   assign found      = rsp_found_ff;

endmodule

FILE: sim/tb_sorted_table_lower_bound.sv
`timescale 1ns / 100ps
// Testbench for sorted_table_lower_bound: streams clear/append/query transactions with random
// idle bursts on both sides and checks every query answer against a lower-bound predictor.
// Depends on stlb_pkg and the sorted_table_lower_bound RTL.
module tb_sorted_table_lower_bound;

   // operation code the block must ignore
   localparam logic [1:0]        OP_RESERVED  = 2'd3;
   localparam int                LIMIT_CYCLES = 2000;
   localparam int                DRAIN_CYCLES = 40;
   localparam int                RANDOM_ITEMS = 150;
   localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX     = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [stlb_pkg::CNT_W-1:0] position;
      logic                       found;
   } bound_answer_type;

   // Mirror of the table plus the queue of query answers still owed by the block
   class lower_bound_scoreboard;
      logic signed [31:0] entries [stlb_pkg::TABLE_DEPTH];
      int                 count;
      int                 failures;
      bound_answer_type   answers [$];

      function new();
         count    = 0;
         failures = 0;
      endfunction

      function void note_request(logic [1:0] op, logic signed [31:0] value);
         int               lo;
         int               hi;
         int               mid;
         bound_answer_type a;
         case (op)
            stlb_pkg::OP_CLEAR: begin
               count = 0;
            end
            stlb_pkg::OP_APPEND: begin
               // a full table drops the value
               if (count < stlb_pkg::TABLE_DEPTH) begin
                  entries[count] = value;
                  count++;
               end
            end
            stlb_pkg::OP_QUERY: begin
               lo = 0;
               hi = count;
               if (hi == 0) begin
                  a.position = '0;
               end else begin
                  // same probe order as the hardware, so unsorted tables match too
                  while (hi - lo > 1) begin
                     mid = lo + (hi - lo) / 2;
                     if (entries[mid] >= value) hi = mid;
                     else lo = mid;
                  end
                  a.position = stlb_pkg::CNT_W'((entries[lo] >= value) ? lo : hi);
               end
               a.found = (a.position < count);
               answers.insert(answers.size(), a);
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [stlb_pkg::CNT_W-1:0] position, logic found);
         bound_answer_type exp_a;
         if (answers.size() == 0) begin
            $error("unexpected result: position %0d found %0b", position, found);
            failures++;
            return;
         end
         exp_a = answers.pop_front();
         if (exp_a.position !== position) begin
            $error("position: expected %0d, actual %0d", exp_a.position, position);
            failures++;
         end
         if (exp_a.found !== found) begin
            $error("found: expected %0b, actual %0b", exp_a.found, found);
            failures++;
         end
      endfunction
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [31:0]                      req_tdata  = '0;   // [31:0] operand_value
   logic [1:0]                       req_tuser  = '0;   // [1:0] operation
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [stlb_pkg::RSP_TDATA_W-1:0] rsp_tdata;         // [10:0] position, rest zero
   logic                             rsp_tuser;         // [0] found

   bit                     idle_enable = 1'b0;
   int                     stall_left  = 0;
   int                     idle_cycles = 0;
   int                     items_sent  = 0;
   lower_bound_scoreboard  table_sb;

   sorted_table_lower_bound DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Result side backpressure: random bursts of stalled cycles
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 16) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result monitor and watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            table_sb.check_response(rsp_tdata[stlb_pkg::CNT_W-1:0], rsp_tuser);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // One request transaction; entered and left at a falling edge
   task automatic send_item(input logic [1:0] op, input logic signed [31:0] value);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      table_sb.note_request(op, value);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold the request side until every owed answer has arrived
   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      while (table_sb.answers.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Key near the table contents most of the time, else extremes or anything
   function automatic logic signed [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (table_sb.count > 0 && sel < 4)
         return table_sb.entries[$urandom_range(0, table_sb.count - 1)];
      if (table_sb.count > 0 && sel < 6)
         return table_sb.entries[$urandom_range(0, table_sb.count - 1)]
                + ($urandom_range(0, 1) ? 1 : -1);
      if (sel == 6) return KEY_MIN;
      if (sel == 7) return KEY_MAX;
      if (sel == 8) return $urandom_range(0, 20) - 10;
      return $urandom;
   endfunction

   // Append n values in ascending order; narrow values give many duplicates
   task automatic load_ascending(input int n, input bit narrow);
      logic signed [31:0] vals [stlb_pkg::TABLE_DEPTH];
      logic signed [31:0] v;
      int                 i;
      int                 j;
      for (i = 0; i < n; i++) begin
         v = narrow ? ($urandom_range(0, 16) - 8) : $urandom;
         j = i;
         while (j > 0 && vals[j-1] > v) begin
            vals[j] = vals[j-1];
            j--;
         end
         vals[j] = v;
      end
      for (i = 0; i < n; i++) send_item(stlb_pkg::OP_APPEND, vals[i]);
   endtask

   initial begin
      int                 start;
      int                 i;
      int                 r;
      logic signed [31:0] v;

      table_sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes, duplicates, ignored code
      send_item(stlb_pkg::OP_QUERY, 32'sd0);
      send_item(OP_RESERVED, KEY_MAX);
      send_item(stlb_pkg::OP_APPEND, KEY_MIN);
      send_item(stlb_pkg::OP_QUERY, KEY_MIN);
      send_item(stlb_pkg::OP_QUERY, KEY_MAX);
      send_item(stlb_pkg::OP_APPEND, -32'sd5);
      send_item(stlb_pkg::OP_APPEND, -32'sd5);
      send_item(stlb_pkg::OP_APPEND, 32'sd0);
      send_item(stlb_pkg::OP_APPEND, 32'sd7);
      send_item(stlb_pkg::OP_APPEND, KEY_MAX);
      send_item(stlb_pkg::OP_QUERY, -32'sd5);
      send_item(stlb_pkg::OP_QUERY, -32'sd4);
      send_item(stlb_pkg::OP_QUERY, 32'sd1);
      send_item(stlb_pkg::OP_QUERY, 32'sd8);
      send_item(stlb_pkg::OP_QUERY, KEY_MAX);
      send_item(stlb_pkg::OP_QUERY, KEY_MIN);
      send_item(stlb_pkg::OP_CLEAR, 32'sd0);
      send_item(stlb_pkg::OP_QUERY, 32'sd0);
      send_item(stlb_pkg::OP_APPEND, 32'sd3);
      send_item(stlb_pkg::OP_QUERY, 32'sd3);
      send_item(stlb_pkg::OP_QUERY, 32'sd4);
      send_item(OP_RESERVED, -32'sd1);
      send_item(stlb_pkg::OP_QUERY, 32'sd2);

      // Full table, then appends that must be dropped
      idle_enable = 1'b1;
      send_item(stlb_pkg::OP_CLEAR, KEY_MAX);
      for (i = 0; i < stlb_pkg::TABLE_DEPTH; i++) begin
         v = KEY_MIN + (i <<< 22) + $urandom_range(0, 4194303);
         send_item(stlb_pkg::OP_APPEND, v);
      end
      send_item(stlb_pkg::OP_APPEND, KEY_MAX);
      send_item(stlb_pkg::OP_APPEND, KEY_MIN);
      send_item(stlb_pkg::OP_QUERY, KEY_MAX);
      send_item(stlb_pkg::OP_QUERY, KEY_MIN);
      repeat (12) send_item(stlb_pkg::OP_QUERY, pick_key());
      wait_for_answers();

      // Random phases, mostly well-formed tables with queries
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         idle_enable = (items_sent - start < RANDOM_ITEMS * 4 / 5) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               send_item(stlb_pkg::OP_CLEAR, $urandom);
               load_ascending(($urandom_range(0, 7) == 0) ? $urandom_range(25, 300)
                                                         : $urandom_range(0, 24),
                              $urandom_range(0, 2) == 0);
               repeat ($urandom_range(3, 12)) send_item(stlb_pkg::OP_QUERY, pick_key());
            end
            6: begin
               // noise: any code, any value
               repeat ($urandom_range(8, 20)) send_item(2'($urandom_range(0, 3)), $urandom);
            end
            7: begin
               // unsorted table
               send_item(stlb_pkg::OP_CLEAR, $urandom);
               repeat ($urandom_range(1, 30)) send_item(stlb_pkg::OP_APPEND, $urandom);
               repeat ($urandom_range(3, 10)) send_item(stlb_pkg::OP_QUERY, pick_key());
            end
            8: begin
               // build interleaved with queries and stray clears
               v = $urandom;
               repeat ($urandom_range(10, 40)) begin
                  r = $urandom_range(0, 9);
                  if (r < 6) begin
                     v = v + $urandom_range(0, 1000);
                     send_item(stlb_pkg::OP_APPEND, v);
                  end else if (r < 9) begin
                     send_item(stlb_pkg::OP_QUERY, pick_key());
                  end else begin
                     send_item(stlb_pkg::OP_CLEAR, v);
                  end
               end
            end
            default: begin
               repeat ($urandom_range(4, 10)) send_item(stlb_pkg::OP_QUERY, pick_key());
            end
         endcase
         if ($urandom_range(0, 7) == 0) wait_for_answers();
      end

      idle_enable = 1'b0;
      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (table_sb.answers.size() != 0)
         $error("%0d query answers never arrived", table_sb.answers.size());
      if (table_sb.failures == 0 && table_sb.answers.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/stlb_pkg.sv
design/stlb_ctrl.sv
design/stlb_datapath.sv
design/sorted_table_lower_bound.sv
sim/tb_sorted_table_lower_bound.sv
